/* sv/pfb_pkg.sv */
// ----------------------------------------------------------------------------
// pfb_pkg
// shared codes and types of the page framebuffer sprite blitter
// ----------------------------------------------------------------------------
package pfb_pkg;

  // item kinds
  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_PIXELS = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  // colour modes, anything else acts as invert
  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_SET    = 2'd1;

  // control part of one queued operation
  typedef struct packed {
    logic       is_read;
    logic       rd_in_range;
    logic [1:0] en;
    logic [1:0] mode;
  } pfb_op_ctrl_t;

endpackage

/* sv/pfb_item_if.sv */
// ----------------------------------------------------------------------------
// pfb_item_if
// input item channel of the blitter
// ----------------------------------------------------------------------------
interface pfb_item_if;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic signed [8:0] pos_x;
  logic signed [8:0] pos_y;
  logic [7:0]        sprite_width;
  logic [7:0]        sprite_height;
  logic [1:0]        colour_mode;
  logic [7:0]        pixels;
  logic [9:0]        read_address;

  modport source (
    output valid, kind, pos_x, pos_y, sprite_width, sprite_height, colour_mode,
           pixels, read_address,
    input  ready
  );
  modport sink (
    input  valid, kind, pos_x, pos_y, sprite_width, sprite_height, colour_mode,
           pixels, read_address,
    output ready
  );
endinterface

/* sv/pfb_result_if.sv */
// ----------------------------------------------------------------------------
// pfb_result_if
// result channel of the blitter, one framebuffer byte per transfer
// ----------------------------------------------------------------------------
interface pfb_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface

/* sv/pfb_ram.sv */
// ----------------------------------------------------------------------------
// pfb_ram
// generic ram, one write port and one read port, registered read data
// ----------------------------------------------------------------------------
module pfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/pfb_queue.sv */
// ----------------------------------------------------------------------------
// pfb_queue
// two-entry queue between the front and back parts
// ----------------------------------------------------------------------------
module pfb_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] ent_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = ent_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("queue push while full");

endmodule

/* sv/pfb_front.sv */
// ----------------------------------------------------------------------------
// pfb_front
// accepts items, tracks the blit position and turns bitmap bytes and reads
// into memory operations
// ----------------------------------------------------------------------------
module pfb_front #(
  parameter int SCREEN_WIDTH = 128,
  parameter int SCREEN_HEIGHT = 64,
  localparam int PageCount = SCREEN_HEIGHT / 8,
  localparam int FrameBytes = SCREEN_WIDTH * PageCount,
  localparam int AddrW = $clog2(FrameBytes)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  pfb_item_if.sink             item_i,
  input  logic                 space_i,
  output logic                 push_o,
  output pfb_pkg::pfb_op_ctrl_t ctrl_o,
  output logic [AddrW-1:0]     addr0_o,
  output logic [AddrW-1:0]     addr1_o,
  output logic [7:0]           bits0_o,
  output logic [7:0]           bits1_o
);
  import pfb_pkg::*;

  localparam logic signed [10:0] XMax = 11'(SCREEN_WIDTH - 1);
  localparam logic signed [10:0] YMax = 11'(SCREEN_HEIGHT - 1);
  localparam logic signed [7:0]  PMax = 8'(PageCount - 1);

  logic signed [8:0] origin_x_q, origin_x_d;
  logic signed [6:0] first_page_q, first_page_d;
  logic [2:0]        bit_shift_q, bit_shift_d;
  logic [7:0]        blit_width_q, blit_width_d;
  logic [1:0]        blit_mode_q, blit_mode_d;
  logic [5:0]        page_cnt_q, page_cnt_d;
  logic [7:0]        col_cnt_q, col_cnt_d;
  logic              visible_q, visible_d;

  logic              accept;
  logic signed [10:0] xs, ys, xw, yh, col;
  logic              off;
  logic signed [7:0] page0, page1;
  logic              col_ok, p0_ok, p1_ok;
  logic [15:0]       shifted;
  logic [8:0]        col_next;
  logic [1:0]        en;

  assign item_i.ready = space_i;
  assign accept = item_i.valid && space_i;

  // start geometry
  assign xs  = {{2{item_i.pos_x[8]}}, item_i.pos_x};
  assign ys  = {{2{item_i.pos_y[8]}}, item_i.pos_y};
  assign xw  = xs + $signed({3'b000, item_i.sprite_width});
  assign yh  = ys + $signed({3'b000, item_i.sprite_height});
  assign off = (xw <= 11'sd0) || (xs > XMax) || (yh <= 11'sd0) || (ys > YMax);

  // target bytes of one bitmap byte
  assign col     = {{2{origin_x_q[8]}}, origin_x_q} + $signed({3'b000, col_cnt_q});
  assign page0   = {first_page_q[6], first_page_q};
  assign page1   = page0 + 8'sd1;
  assign col_ok  = !col[10] && (col <= XMax);
  assign p0_ok   = !page0[7] && (page0 <= PMax);
  assign p1_ok   = !page1[7] && (page1 <= PMax);
  assign shifted = {8'h00, item_i.pixels} << bit_shift_q;
  assign en      = {p1_ok && col_ok && (bit_shift_q != 3'd0), p0_ok && col_ok};
  assign col_next = {1'b0, col_cnt_q} + 9'd1;

  always_comb begin
    origin_x_d   = origin_x_q;
    first_page_d = first_page_q;
    bit_shift_d  = bit_shift_q;
    blit_width_d = blit_width_q;
    blit_mode_d  = blit_mode_q;
    page_cnt_d   = page_cnt_q;
    col_cnt_d    = col_cnt_q;
    visible_d    = visible_q;
    push_o       = 1'b0;
    ctrl_o       = '0;
    ctrl_o.mode  = blit_mode_q;
    addr0_o      = AddrW'(32'(page0[5:0]) * SCREEN_WIDTH + 32'(col[9:0]));
    addr1_o      = AddrW'(32'(page1[6:0]) * SCREEN_WIDTH + 32'(col[9:0]));
    bits0_o      = shifted[7:0];
    bits1_o      = shifted[15:8];
    if (accept) begin
      unique case (item_i.kind)
        KIND_START: begin
          origin_x_d   = item_i.pos_x;
          first_page_d = {item_i.pos_y[8], item_i.pos_y[8:3]};
          bit_shift_d  = item_i.pos_y[2:0];
          blit_width_d = item_i.sprite_width;
          blit_mode_d  = item_i.colour_mode;
          page_cnt_d   = {1'b0, item_i.sprite_height[7:3]}
                         + 6'(|item_i.sprite_height[2:0]);
          col_cnt_d    = 8'd0;
          visible_d    = !off && (item_i.sprite_width != 8'd0)
                         && (item_i.sprite_height != 8'd0);
        end
        KIND_PIXELS: begin
          if (visible_q) begin
            ctrl_o.en = en;
            push_o    = (en != 2'b00);
            if (col_next >= {1'b0, blit_width_q}) begin
              col_cnt_d    = 8'd0;
              first_page_d = first_page_q + 7'sd1;
              page_cnt_d   = page_cnt_q - 6'd1;
              if ((page_cnt_q == 6'd1) || (page1 > PMax)) begin
                visible_d = 1'b0;
              end
            end else begin
              col_cnt_d = col_next[7:0];
            end
          end
        end
        KIND_READ: begin
          push_o             = 1'b1;
          ctrl_o.is_read     = 1'b1;
          ctrl_o.en          = 2'b01;
          ctrl_o.rd_in_range = (32'(item_i.read_address) < 32'(FrameBytes));
          addr0_o            = AddrW'(item_i.read_address);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q   <= '0;
      first_page_q <= '0;
      bit_shift_q  <= '0;
      blit_width_q <= '0;
      blit_mode_q  <= '0;
      page_cnt_q   <= '0;
      col_cnt_q    <= '0;
      visible_q    <= 1'b0;
    end else begin
      origin_x_q   <= origin_x_d;
      first_page_q <= first_page_d;
      bit_shift_q  <= bit_shift_d;
      blit_width_q <= blit_width_d;
      blit_mode_q  <= blit_mode_d;
      page_cnt_q   <= page_cnt_d;
      col_cnt_q    <= col_cnt_d;
      visible_q    <= visible_d;
    end
  end

  a_visible_has_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    visible_q |-> (page_cnt_q != 6'd0) && (col_cnt_q < blit_width_q))
    else $error("active blit without remaining bytes");

endmodule

/* sv/pfb_back.sv */
// ----------------------------------------------------------------------------
// pfb_back
// clears the framebuffer after reset, then runs queued read-modify-writes
// and reads against the frame memory
// ----------------------------------------------------------------------------
module pfb_back #(
  parameter int SCREEN_WIDTH = 128,
  parameter int SCREEN_HEIGHT = 64,
  localparam int PageCount = SCREEN_HEIGHT / 8,
  localparam int FrameBytes = SCREEN_WIDTH * PageCount,
  localparam int AddrW = $clog2(FrameBytes)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  pfb_pkg::pfb_op_ctrl_t q_ctrl_i,
  input  logic [AddrW-1:0]      q_addr0_i,
  input  logic [AddrW-1:0]      q_addr1_i,
  input  logic [7:0]            q_bits0_i,
  input  logic [7:0]            q_bits1_i,
  output logic                  q_pop_o,
  output logic                  clearing_o,
  pfb_result_if.source          result_o
);
  import pfb_pkg::*;

  localparam logic [AddrW-1:0] LastAddr = AddrW'(FrameBytes - 1);

  logic             clearing_q;
  logic [AddrW-1:0] clr_cnt_q;
  logic             sub_q;

  logic             cur_hi, last, issue, credit_ok, b_rd;
  logic [AddrW-1:0] cur_addr;
  logic [7:0]       cur_bits;

  logic             b_valid_q, b_is_read_q, b_in_range_q;
  logic [1:0]       b_mode_q;
  logic [AddrW-1:0] b_addr_q;
  logic [7:0]       b_bits_q;
  logic             fwd_hit_q;
  logic [7:0]       fwd_data_q;

  logic [7:0]       ram_rdata, cur_b, merged;
  logic             we;
  logic [AddrW-1:0] waddr;
  logic [7:0]       wdata;

  logic [7:0]       out_q [2];
  logic             out_wr_q, out_rd_q;
  logic [1:0]       out_cnt_q;
  logic             res_push, res_pop;

  assign clearing_o = clearing_q;

  // pick the next target of the head operation
  assign cur_hi   = sub_q || !q_ctrl_i.en[0];
  assign last     = cur_hi || !q_ctrl_i.en[1];
  assign cur_addr = cur_hi ? q_addr1_i : q_addr0_i;
  assign cur_bits = cur_hi ? q_bits1_i : q_bits0_i;

  // a read only goes ahead when the result buffer is sure to have room
  assign b_rd      = b_valid_q && b_is_read_q;
  assign res_pop   = result_o.valid && result_o.ready;
  assign credit_ok = ({1'b0, out_cnt_q} + 3'(b_rd) - 3'(res_pop)) <= 3'd1;
  assign issue     = q_valid_i && !clearing_q && (!q_ctrl_i.is_read || credit_ok);
  assign q_pop_o   = issue && last;

  // read data, with the write of the cycle before forwarded
  assign cur_b = fwd_hit_q ? fwd_data_q : ram_rdata;

  always_comb begin
    unique case (b_mode_q)
      MODE_CLEAR: merged = cur_b & ~b_bits_q;
      MODE_SET:   merged = cur_b | b_bits_q;
      default:    merged = cur_b ^ b_bits_q;
    endcase
  end

  assign we    = clearing_q || (b_valid_q && !b_is_read_q);
  assign waddr = clearing_q ? clr_cnt_q : b_addr_q;
  assign wdata = clearing_q ? 8'h00 : merged;

  pfb_ram #(
    .WIDTH (8),
    .DEPTH (FrameBytes)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (issue),
    .raddr_i (cur_addr),
    .rdata_o (ram_rdata)
  );

  assign res_push         = b_rd;
  assign result_o.valid     = (out_cnt_q != 2'd0);
  assign result_o.read_data = out_q[out_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
      sub_q      <= 1'b0;
      b_valid_q  <= 1'b0;
      fwd_hit_q  <= 1'b0;
      out_wr_q   <= 1'b0;
      out_rd_q   <= 1'b0;
      out_cnt_q  <= 2'd0;
    end else begin
      if (clearing_q) begin
        clr_cnt_q <= clr_cnt_q + AddrW'(1);
        if (clr_cnt_q == LastAddr) begin
          clearing_q <= 1'b0;
        end
      end
      if (issue) begin
        sub_q <= !last;
      end
      b_valid_q <= issue;
      fwd_hit_q <= issue && b_valid_q && !b_is_read_q && (cur_addr == b_addr_q);
      if (res_push) begin
        out_wr_q <= !out_wr_q;
      end
      if (res_pop) begin
        out_rd_q <= !out_rd_q;
      end
      if (res_push && !res_pop) begin
        out_cnt_q <= out_cnt_q + 2'd1;
      end else if (res_pop && !res_push) begin
        out_cnt_q <= out_cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      b_is_read_q  <= q_ctrl_i.is_read;
      b_in_range_q <= q_ctrl_i.rd_in_range;
      b_mode_q     <= q_ctrl_i.mode;
      b_addr_q     <= cur_addr;
      b_bits_q     <= cur_bits;
    end
    fwd_data_q <= merged;
    if (res_push) begin
      out_q[out_wr_q] <= b_in_range_q ? cur_b : 8'h00;
    end
  end

  a_no_issue_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !issue && !b_valid_q)
    else $error("operation issued during clearing pass");

  a_result_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> (out_cnt_q != 2'd2) || res_pop)
    else $error("result buffer overflow");

  a_fwd_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_hit_q |-> $past(b_valid_q && !b_is_read_q))
    else $error("forward without preceding write");

endmodule

/* sv/page_framebuffer_sprite_blit.sv */
// ----------------------------------------------------------------------------
// page_framebuffer_sprite_blit
// blits 1-bit bitmaps into a page-organized monochrome framebuffer
// ----------------------------------------------------------------------------
// After reset the block clears all SCREEN_WIDTH*SCREEN_HEIGHT/8 bytes (1024 with
// the default 128x64 screen) of the frame memory, with item_i.ready low.
// From then on the front part takes one item per cycle as long as the
// two-entry operation queue has room. Start items and off-screen or ignored
// bytes push nothing into the queue. Each bitmap byte becomes up to two
// read-modify-writes of framebuffer bytes and each read becomes one memory
// read; the back part runs one of these per cycle, unless a read is held,
// through the frame memory's single write port, so a bitmap byte that
// straddles two pages is run as two of them. A read result passes through
// the operation queue and the registered memory read and is held in a
// two-entry buffer; when that buffer has no room, a stalled result side holds
// the read at the head of the queue, everything queued behind it waits, and
// item_i.ready drops once the queue is full.
// ----------------------------------------------------------------------------
module page_framebuffer_sprite_blit #(
  parameter int SCREEN_WIDTH = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  pfb_item_if.sink      item_i,
  pfb_result_if.source  result_o
);
  import pfb_pkg::*;

  localparam int PageCount  = SCREEN_HEIGHT / 8;
  localparam int FrameBytes = SCREEN_WIDTH * PageCount;
  localparam int AddrW      = $clog2(FrameBytes);
  localparam int EntryW     = $bits(pfb_op_ctrl_t) + 2 * AddrW + 16;

  // front to queue
  logic             f_push;
  pfb_op_ctrl_t     f_ctrl;
  logic [AddrW-1:0] f_addr0, f_addr1;
  logic [7:0]       f_bits0, f_bits1;

  // queue to back
  logic              q_full, q_valid, q_pop;
  logic [EntryW-1:0] q_in, q_out;
  pfb_op_ctrl_t      q_ctrl;
  logic [AddrW-1:0]  q_addr0, q_addr1;
  logic [7:0]        q_bits0, q_bits1;

  logic clearing;
  logic space;

  // no transfers while the memory is being cleared
  assign space = !q_full && !clearing;

  pfb_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_i),
    .space_i (space),
    .push_o  (f_push),
    .ctrl_o  (f_ctrl),
    .addr0_o (f_addr0),
    .addr1_o (f_addr1),
    .bits0_o (f_bits0),
    .bits1_o (f_bits1)
  );

  assign q_in = {f_ctrl, f_addr0, f_addr1, f_bits0, f_bits1};

  pfb_queue #(
    .WIDTH (EntryW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_out)
  );

  assign {q_ctrl, q_addr0, q_addr1, q_bits0, q_bits1} = q_out;

  pfb_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_ctrl_i   (q_ctrl),
    .q_addr0_i  (q_addr0),
    .q_addr1_i  (q_addr1),
    .q_bits0_i  (q_bits0),
    .q_bits1_i  (q_bits1),
    .q_pop_o    (q_pop),
    .clearing_o (clearing),
    .result_o   (result_o)
  );

endmodule
